@@ sv/gn2d_pkg.sv @@
package gn2d_pkg;

   localparam int TableSize    = 5;
   localparam int NumGradients = 5;
   localparam int GradWidth    = 13;
   localparam int CoordWidth   = 32;
   localparam int FracBits     = 12;
   localparam int CellWidth    = CoordWidth - FracBits;
   localparam int OneFx        = 1 << FracBits;
   localparam int XStride      = 12;
   localparam int YStride      = 14;

   localparam int CellIdxWidth = $clog2(TableSize + 1);
   localparam int GradIdxWidth = $clog2(TableSize);

   // biased cell is always non-negative and keeps its residue modulo TableSize
   localparam int BiasedWidth  = CellWidth + 1;
   localparam int CellBias     = TableSize * ((2 ** (CellWidth - 1) + TableSize - 1) / TableSize);
   localparam int RecipShift   = BiasedWidth + 4;
   localparam int RecipMul     = (2 ** RecipShift + TableSize - 1) / TableSize;
   localparam int ProdWidth    = BiasedWidth + RecipShift;

   localparam int TWidth       = FracBits + 1;
   localparam int WeightWidth  = FracBits + 2;
   localparam int DeltaWidth   = FracBits + 2;
   localparam int DotWidth     = FracBits + 3;
   localparam int TermWidth    = FracBits + 4;
   localparam int SumWidth     = TermWidth + 2;

   localparam int CsrAddrWidth = $clog2(4 * NumGradients);
   localparam int CsrIdxWidth  = CsrAddrWidth - 2;
   localparam int CsrDataWidth = 32;

   localparam int GradResetVal [NumGradients] = '{3686, -1638, 2457, -2048, 1228};

   typedef logic [GradWidth-1:0] grad_type;
   typedef grad_type [NumGradients-1:0] grad_tab_type;

   typedef struct packed {
      logic                          valid;
      logic signed [GradWidth-1:0]   gx0;
      logic signed [GradWidth-1:0]   gx1;
      logic signed [GradWidth-1:0]   gy0;
      logic signed [GradWidth-1:0]   gy1;
      logic [FracBits-1:0]           fx;
      logic [FracBits-1:0]           fy;
      logic [WeightWidth-1:0]        wx0;
      logic [WeightWidth-1:0]        wx1;
      logic [WeightWidth-1:0]        wy0;
      logic [WeightWidth-1:0]        wy1;
   } lattice_type;

   // gradient slot for a wrapped cell (0..TableSize) and a lattice stride
   function automatic logic [GradIdxWidth-1:0] grad_index(input logic [CellIdxWidth-1:0] lat_idx,
                                                          input int stride);
      logic [GradIdxWidth-1:0] idx;
      idx = '0;
      for (int i = 0; i <= TableSize; i++) begin
         if (int'(lat_idx) == i) begin
            idx = GradIdxWidth'((i * stride) % TableSize);
         end
      end
      return idx;
   endfunction

   // slots past the register file read as zero
   function automatic logic signed [GradWidth-1:0] grad_pick(input grad_tab_type tab,
                                                             input logic [GradIdxWidth-1:0] idx);
      logic signed [GradWidth-1:0] g;
      g = '0;
      for (int i = 0; i < NumGradients; i++) begin
         if (int'(idx) == i) begin
            g = $signed(tab[i]);
         end
      end
      return g;
   endfunction

endpackage

@@ sv/gradient_noise_2d_fixed.sv @@
// A req word goes through front stages s1-s4 and back stages b1-b3 to rsp_tvalid.
// Throughput: one point per cycle; every pipeline stage holds its word only while the
// stage after it is full and stalled, so bubbles close up under back pressure.
// Reset (synchronous, active high) empties the pipeline and restores the gradient table.
module gradient_noise_2d_fixed (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [2*gn2d_pkg::CoordWidth-1:0]     req_tdata,   // coord_x, coord_y
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [gn2d_pkg::CoordWidth-1:0]       rsp_tdata,   // noise_value
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [gn2d_pkg::CsrAddrWidth-1:0]     csr_paddr,
   input  logic [gn2d_pkg::CsrDataWidth-1:0]     csr_pwdata,
   output logic [gn2d_pkg::CsrDataWidth-1:0]     csr_prdata,
   output logic                                  csr_pready
);

   gn2d_pkg::grad_tab_type  grad_tab;
   gn2d_pkg::lattice_type   lattice;
   logic                    back_ready;

   gn2d_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .grad_tab    (grad_tab)
   );

   gn2d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .coord_x   (req_tdata[gn2d_pkg::CoordWidth-1:0]),
      .coord_y   (req_tdata[2*gn2d_pkg::CoordWidth-1:gn2d_pkg::CoordWidth]),
      .grad_tab  (grad_tab),
      .out_word  (lattice),
      .out_ready (back_ready)
   );

   gn2d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_word    (lattice),
      .in_ready   (back_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ sv/gn2d_csr.sv @@
module gn2d_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [gn2d_pkg::CsrAddrWidth-1:0]     csr_paddr,
   input  logic [gn2d_pkg::CsrDataWidth-1:0]     csr_pwdata,
   output logic [gn2d_pkg::CsrDataWidth-1:0]     csr_prdata,
   output logic                                  csr_pready,
   output gn2d_pkg::grad_tab_type                grad_tab
);

   gn2d_pkg::grad_tab_type                grad_ff;
   gn2d_pkg::grad_tab_type                grad_in;
   logic [gn2d_pkg::CsrIdxWidth-1:0]      reg_idx;
   logic                                  wr_en;

   assign reg_idx    = csr_paddr[gn2d_pkg::CsrAddrWidth-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign grad_tab   = grad_ff;

   always_comb begin
      grad_in = grad_ff;
      for (int i = 0; i < gn2d_pkg::NumGradients; i++) begin
         if (wr_en && int'(reg_idx) == i) begin
            grad_in[i] = csr_pwdata[gn2d_pkg::GradWidth-1:0];
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      for (int i = 0; i < gn2d_pkg::NumGradients; i++) begin
         if (int'(reg_idx) == i) begin
            csr_prdata = {{(gn2d_pkg::CsrDataWidth - gn2d_pkg::GradWidth)
                           {grad_ff[i][gn2d_pkg::GradWidth-1]}}, grad_ff[i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gn2d_pkg::NumGradients; i++) begin
            grad_ff[i] <= gn2d_pkg::GradWidth'(gn2d_pkg::GradResetVal[i]);
         end
      end else begin
         grad_ff <= grad_in;
      end
   end

endmodule

@@ sv/gn2d_front.sv @@
module gn2d_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic [gn2d_pkg::CoordWidth-1:0]       coord_x,
   input  logic [gn2d_pkg::CoordWidth-1:0]       coord_y,
   input  gn2d_pkg::grad_tab_type                grad_tab,
   output gn2d_pkg::lattice_type                 out_word,
   input  logic                                  out_ready
);

   localparam int TW = gn2d_pkg::TWidth;
   localparam int BW = gn2d_pkg::BiasedWidth;
   localparam int FB = gn2d_pkg::FracBits;
   localparam int CW = gn2d_pkg::CellIdxWidth;
   localparam int SW = gn2d_pkg::WeightWidth + 1;

   function automatic logic [TW-1:0] frac_mul(input logic [TW-1:0] a, input logic [TW-1:0] b);
      logic [2*TW-1:0] p;
      p = a * b;
      return p[FB +: TW];
   endfunction

   // stage 1: biased cells and fractions
   logic                 s1_valid_ff;
   logic [BW-1:0]        s1_vx_ff, s1_vy_ff, s1_vx_in, s1_vy_in;
   logic [FB-1:0]        s1_fx_ff, s1_fy_ff;

   // stage 2: reciprocal quotients and squared fade inputs
   logic                 s2_valid_ff;
   logic [BW-1:0]        s2_vx_ff, s2_vy_ff, s2_qx_ff, s2_qy_ff, s2_qx_in, s2_qy_in;
   logic [FB-1:0]        s2_fx_ff, s2_fy_ff;
   logic [3:0][TW-1:0]   s2_t_ff, s2_t2_ff, s2_t_in, s2_t2_in;
   logic [gn2d_pkg::ProdWidth-1:0] prod_x, prod_y;

   // stage 3: wrapped cells and cubed fade inputs
   logic                 s3_valid_ff;
   logic [CW-1:0]        s3_cx_ff, s3_cy_ff, s3_cx_in, s3_cy_in;
   logic [FB-1:0]        s3_fx_ff, s3_fy_ff;
   logic [3:0][TW-1:0]   s3_t2_ff, s3_t3_ff, s3_t3_in;
   logic [BW-1:0]        diff_x, diff_y;

   // stage 4: fade weights and gradients
   gn2d_pkg::lattice_type s4_ff, s4_in;
   logic [CW-1:0]         cx1, cy1;
   logic [3:0][SW-1:0]    fade;

   logic en1, en2, en3, en4;

   assign en4      = !s4_ff.valid || out_ready;
   assign en3      = !s3_valid_ff || en4;
   assign en2      = !s2_valid_ff || en3;
   assign en1      = !s1_valid_ff || en2;
   assign in_ready = en1;
   assign out_word = s4_ff;

   always_comb begin
      s1_vx_in = {{(BW - gn2d_pkg::CellWidth){coord_x[gn2d_pkg::CoordWidth-1]}},
                  coord_x[gn2d_pkg::CoordWidth-1:FB]} + BW'(gn2d_pkg::CellBias);
      s1_vy_in = {{(BW - gn2d_pkg::CellWidth){coord_y[gn2d_pkg::CoordWidth-1]}},
                  coord_y[gn2d_pkg::CoordWidth-1:FB]} + BW'(gn2d_pkg::CellBias);
   end

   always_comb begin
      prod_x   = gn2d_pkg::ProdWidth'(s1_vx_ff) * gn2d_pkg::ProdWidth'(gn2d_pkg::RecipMul);
      prod_y   = gn2d_pkg::ProdWidth'(s1_vy_ff) * gn2d_pkg::ProdWidth'(gn2d_pkg::RecipMul);
      s2_qx_in = prod_x[gn2d_pkg::RecipShift +: BW];
      s2_qy_in = prod_y[gn2d_pkg::RecipShift +: BW];
      s2_t_in[0] = TW'(gn2d_pkg::OneFx) - {1'b0, s1_fx_ff};
      s2_t_in[1] = {1'b0, s1_fx_ff};
      s2_t_in[2] = TW'(gn2d_pkg::OneFx) - {1'b0, s1_fy_ff};
      s2_t_in[3] = {1'b0, s1_fy_ff};
      for (int i = 0; i < 4; i++) begin
         s2_t2_in[i] = frac_mul(s2_t_in[i], s2_t_in[i]);
      end
   end

   always_comb begin
      diff_x   = s2_vx_ff - BW'(s2_qx_ff * gn2d_pkg::TableSize);
      diff_y   = s2_vy_ff - BW'(s2_qy_ff * gn2d_pkg::TableSize);
      s3_cx_in = diff_x[CW-1:0];
      s3_cy_in = diff_y[CW-1:0];
      for (int i = 0; i < 4; i++) begin
         s3_t3_in[i] = frac_mul(s2_t_ff[i], s2_t2_ff[i]);
      end
   end

   always_comb begin
      // fade = 3*t^2 - 2*t^3
      for (int i = 0; i < 4; i++) begin
         fade[i] = (SW'(s3_t2_ff[i]) << 1) + SW'(s3_t2_ff[i]) - (SW'(s3_t3_ff[i]) << 1);
      end
      cx1         = s3_cx_ff + CW'(1);
      cy1         = s3_cy_ff + CW'(1);
      s4_in.valid = s3_valid_ff;
      s4_in.gx0   = gn2d_pkg::grad_pick(grad_tab,
                       gn2d_pkg::grad_index(s3_cx_ff, gn2d_pkg::XStride));
      s4_in.gx1   = gn2d_pkg::grad_pick(grad_tab, gn2d_pkg::grad_index(cx1, gn2d_pkg::XStride));
      s4_in.gy0   = gn2d_pkg::grad_pick(grad_tab,
                       gn2d_pkg::grad_index(s3_cy_ff, gn2d_pkg::YStride));
      s4_in.gy1   = gn2d_pkg::grad_pick(grad_tab, gn2d_pkg::grad_index(cy1, gn2d_pkg::YStride));
      s4_in.fx    = s3_fx_ff;
      s4_in.fy    = s3_fy_ff;
      s4_in.wx0   = fade[0][gn2d_pkg::WeightWidth-1:0];
      s4_in.wx1   = fade[1][gn2d_pkg::WeightWidth-1:0];
      s4_in.wy0   = fade[2][gn2d_pkg::WeightWidth-1:0];
      s4_in.wy1   = fade[3][gn2d_pkg::WeightWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_ff.valid <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= in_valid;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
         if (en4) s4_ff.valid <= s4_in.valid;
      end
      if (en1) begin
         s1_vx_ff <= s1_vx_in;
         s1_vy_ff <= s1_vy_in;
         s1_fx_ff <= coord_x[FB-1:0];
         s1_fy_ff <= coord_y[FB-1:0];
      end
      if (en2) begin
         s2_vx_ff <= s1_vx_ff;
         s2_vy_ff <= s1_vy_ff;
         s2_qx_ff <= s2_qx_in;
         s2_qy_ff <= s2_qy_in;
         s2_fx_ff <= s1_fx_ff;
         s2_fy_ff <= s1_fy_ff;
         s2_t_ff  <= s2_t_in;
         s2_t2_ff <= s2_t2_in;
      end
      if (en3) begin
         s3_cx_ff <= s3_cx_in;
         s3_cy_ff <= s3_cy_in;
         s3_fx_ff <= s2_fx_ff;
         s3_fy_ff <= s2_fy_ff;
         s3_t2_ff <= s2_t2_ff;
         s3_t3_ff <= s3_t3_in;
      end
      if (en4) begin
         s4_ff.gx0 <= s4_in.gx0;
         s4_ff.gx1 <= s4_in.gx1;
         s4_ff.gy0 <= s4_in.gy0;
         s4_ff.gy1 <= s4_in.gy1;
         s4_ff.fx  <= s4_in.fx;
         s4_ff.fy  <= s4_in.fy;
         s4_ff.wx0 <= s4_in.wx0;
         s4_ff.wx1 <= s4_in.wx1;
         s4_ff.wy0 <= s4_in.wy0;
         s4_ff.wy1 <= s4_in.wy1;
      end
   end

endmodule

@@ sv/gn2d_back.sv @@
module gn2d_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gn2d_pkg::lattice_type                 in_word,
   output logic                                  in_ready,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [gn2d_pkg::CoordWidth-1:0]       rsp_tdata
);

   localparam int FB  = gn2d_pkg::FracBits;
   localparam int DW  = gn2d_pkg::DeltaWidth;
   localparam int GW  = gn2d_pkg::GradWidth;
   localparam int SDW = gn2d_pkg::DotWidth;
   localparam int WW  = gn2d_pkg::WeightWidth;
   localparam int TMW = gn2d_pkg::TermWidth;
   localparam int SMW = gn2d_pkg::SumWidth;

   function automatic logic signed [SDW-1:0] dot(input logic signed [DW-1:0] d,
                                                 input logic signed [GW-1:0] g);
      logic signed [DW+GW-1:0] p;
      p = d * g;
      return p[FB +: SDW];
   endfunction

   function automatic logic [WW-1:0] wmul(input logic [WW-1:0] a, input logic [WW-1:0] b);
      logic [2*WW-1:0] p;
      p = a * b;
      return p[FB +: WW];
   endfunction

   function automatic logic signed [TMW-1:0] term(input logic [WW-1:0] w,
                                                  input logic signed [SDW-1:0] s);
      logic signed [WW+SDW:0] p;
      p = $signed({1'b0, w}) * s;
      return p[FB +: TMW];
   endfunction

   logic                      b1_valid_ff;
   logic signed [SDW-1:0]     b1_s_ff [4];
   logic signed [SDW-1:0]     b1_s_in [4];
   logic [WW-1:0]             b1_w_ff [4];
   logic [WW-1:0]             b1_w_in [4];
   logic signed [DW-1:0]      dxa, dxb, dya, dyb;

   logic                      b2_valid_ff;
   logic signed [TMW-1:0]     b2_t_ff [4];
   logic signed [TMW-1:0]     b2_t_in [4];

   logic                      b3_valid_ff;
   logic [gn2d_pkg::CoordWidth-1:0] b3_data_ff, b3_data_in;
   logic signed [SMW-1:0]     sum;

   logic en1, en2, en3;

   assign en3        = !b3_valid_ff || rsp_tready;
   assign en2        = !b2_valid_ff || en3;
   assign en1        = !b1_valid_ff || en2;
   assign in_ready   = en1;
   assign rsp_tvalid = b3_valid_ff;
   assign rsp_tdata  = b3_data_ff;

   always_comb begin
      dxa = $signed({2'b00, in_word.fx});
      dxb = dxa - DW'(gn2d_pkg::OneFx);
      dya = $signed({2'b00, in_word.fy});
      dyb = dya - DW'(gn2d_pkg::OneFx);
      // corners in order: (0,0), (1,0), (0,1), (1,1)
      b1_s_in[0] = dot(dxa, in_word.gx0) + dot(dya, in_word.gy0);
      b1_s_in[1] = dot(dxb, in_word.gx1) + dot(dya, in_word.gy0);
      b1_s_in[2] = dot(dxa, in_word.gx0) + dot(dyb, in_word.gy1);
      b1_s_in[3] = dot(dxb, in_word.gx1) + dot(dyb, in_word.gy1);
      b1_w_in[0] = wmul(in_word.wx0, in_word.wy0);
      b1_w_in[1] = wmul(in_word.wx1, in_word.wy0);
      b1_w_in[2] = wmul(in_word.wx0, in_word.wy1);
      b1_w_in[3] = wmul(in_word.wx1, in_word.wy1);
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         b2_t_in[i] = term(b1_w_ff[i], b1_s_ff[i]);
      end
   end

   always_comb begin
      sum = SMW'(b2_t_ff[0]) + SMW'(b2_t_ff[1]) + SMW'(b2_t_ff[2]) + SMW'(b2_t_ff[3]);
      b3_data_in = {{(gn2d_pkg::CoordWidth - SMW){sum[SMW-1]}}, sum};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
      end else begin
         if (en1) b1_valid_ff <= in_word.valid;
         if (en2) b2_valid_ff <= b1_valid_ff;
         if (en3) b3_valid_ff <= b2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         b1_s_ff <= b1_s_in;
         b1_w_ff <= b1_w_in;
      end
      if (en2) begin
         b2_t_ff <= b2_t_in;
      end
      if (en3) begin
         b3_data_ff <= b3_data_in;
      end
   end

endmodule

@@ bench/gradient_noise_2d_fixed_tb.sv @@
module gradient_noise_2d_fixed_tb;
   import gn2d_pkg::*;

   localparam int RegStride   = 4;
   localparam int PipeLatency = 7;
   localparam int DrainSlack  = 2 * PipeLatency + 4;
   localparam int DrainLimit  = 50000;
   localparam int NumPhases   = 7;
   localparam int PhasePoints = 180;
   localparam int NumDirected = 20;
   localparam int GradMax     = 4095;
   localparam int GradMin     = -4095;
   localparam int GradWrapMin = -4096;

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_HEAVY} rx_mode_type;

   localparam logic [31:0] DirX [NumDirected] = '{
      32'h0000_0000, 32'h0000_0FFF, 32'h0000_1000, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_F000, 32'h0000_4800,
      32'hFFFF_B000, 32'hFFFF_A000, 32'h0000_0800, 32'h7FFF_F000, 32'hAAAA_AAAA,
      32'h5555_5555, 32'h0000_3FFF, 32'h0000_0001, 32'h0001_3000, 32'h8000_0800};
   localparam logic [31:0] DirY [NumDirected] = '{
      32'h0000_0000, 32'h0000_0FFF, 32'h0000_1000, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_F000, 32'h0000_4123,
      32'hFFFF_A001, 32'h0000_9FFF, 32'h0000_0800, 32'h8000_0FFF, 32'h5555_5555,
      32'hAAAA_AAAA, 32'h0000_4000, 32'hFFFF_FFFF, 32'hFFFE_C000, 32'h7FFF_F800};

   class noise_scoreboard;
      logic [31:0] grad_tab [NumGradients];
      logic [31:0] pending_noise [$];
      int          checked;
      int          errors;

      function new();
         for (int i = 0; i < NumGradients; i++) begin
            grad_tab[i] = 32'(GradResetVal[i]);
         end
         checked = 0;
         errors  = 0;
      endfunction

      // only the low 13 bits count, sign-extended
      function void write_gradient(int idx, logic [31:0] value);
         if (idx >= NumGradients) begin
            return;
         end
         grad_tab[idx] = {{19{value[12]}}, value[12:0]};
      endfunction

      function logic [31:0] gradient_at(int idx);
         if (idx >= NumGradients) begin
            return '0;
         end
         return grad_tab[idx];
      endfunction

      // (a*b) >> 12 with floor, truncated to 32 bits
      function logic [31:0] mul_fx(logic [31:0] a, logic [31:0] b);
         longint p;
         p = longint'($signed(a)) * longint'($signed(b));
         return 32'(p >>> FracBits);
      endfunction

      function logic [31:0] fade(logic [31:0] t);
         logic [31:0] t2;
         logic [31:0] t3;
         t2 = mul_fx(t, t);
         t3 = mul_fx(t, t2);
         return mul_fx(32'(3 * OneFx), t2) - mul_fx(32'(2 * OneFx), t3);
      endfunction

      function int lattice_of(logic [31:0] coord);
         longint v;
         v = (longint'($signed(coord)) >>> FracBits) % TableSize;
         if (v < 0) begin
            v += TableSize;
         end
         return int'(v);
      endfunction

      function logic [31:0] corner_dot(logic [31:0] dx, logic [31:0] dy, int lx, int ly);
         return mul_fx(dx, gradient_at((lx * XStride) % TableSize))
              + mul_fx(dy, gradient_at((ly * YStride) % TableSize));
      endfunction

      function logic [31:0] predict_noise(logic [31:0] x, logic [31:0] y);
         int          lx;
         int          ly;
         logic [31:0] fx, fy, fxm, fym;
         logic [31:0] s00, s10, s01, s11;
         logic [31:0] wx0, wx1, wy0, wy1;
         lx  = lattice_of(x);
         ly  = lattice_of(y);
         fx  = x & 32'hFFF;
         fy  = y & 32'hFFF;
         fxm = fx - 32'(OneFx);
         fym = fy - 32'(OneFx);
         s00 = corner_dot(fx, fy, lx, ly);
         s10 = corner_dot(fxm, fy, lx + 1, ly);
         s01 = corner_dot(fx, fym, lx, ly + 1);
         s11 = corner_dot(fxm, fym, lx + 1, ly + 1);
         wx0 = fade(32'(OneFx) - fx);
         wx1 = fade(fx);
         wy0 = fade(32'(OneFx) - fy);
         wy1 = fade(fy);
         return mul_fx(mul_fx(wx0, wy0), s00) + mul_fx(mul_fx(wx1, wy0), s10)
              + mul_fx(mul_fx(wx0, wy1), s01) + mul_fx(mul_fx(wx1, wy1), s11);
      endfunction

      function void note_point(logic [31:0] x, logic [31:0] y);
         pending_noise.push_back(predict_noise(x, y));
      endfunction

      function void check_noise(logic [31:0] got);
         logic [31:0] want;
         if (pending_noise.size() == 0) begin
            $display("%0t: unexpected noise word: expected none, got %h", $time, got);
            errors++;
            return;
         end
         want = pending_noise.pop_front();
         checked++;
         if (got !== want) begin
            $display("%0t: noise mismatch: expected %h, got %h", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [2*CoordWidth-1:0] req_tdata   = '0;   // coord_x, coord_y
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [CoordWidth-1:0]   rsp_tdata;          // noise_value
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr   = '0;
   logic [CsrDataWidth-1:0] csr_pwdata  = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   noise_scoreboard sb;
   rx_mode_type     rx_mode = RX_ALWAYS;
   int              rx_count = 0;
   int              points_sent = 0;
   int              csr_errors = 0;

   gradient_noise_2d_fixed dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("timeout at %0t", $time);
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      rx_count <= rx_count + 1;
      case (rx_mode)
         RX_ALWAYS:  rsp_tready <= 1'b1;
         RX_RANDOM:  rsp_tready <= ($urandom_range(0, 3) != 0);
         RX_PATTERN: rsp_tready <= ((rx_count % 11) < 7);
         default:    rsp_tready <= ($urandom_range(0, 9) < 3);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_noise(rsp_tdata);
      end
   end

   task automatic csr_write(input int idx, input logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CsrAddrWidth'(idx * RegStride);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      sb.write_gradient(idx, data);
   endtask

   task automatic csr_read(input int idx, output logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CsrAddrWidth'(idx * RegStride);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // hold the word until the block takes it; valid stays up for the next word
   task automatic send_point(input logic [31:0] x, input logic [31:0] y);
      req_tdata  <= {y, x};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_point(x, y);
      points_sent++;
   endtask

   task automatic idle_cycles(input int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drained();
      int waited;
      waited = 0;
      while (sb.pending_noise.size() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      if (sb.pending_noise.size() != 0) begin
         $display("%0t: %0d noise words never arrived", $time, sb.pending_noise.size());
         $display("*** FAILED ***");
         $finish;
      end else begin
         repeat (DrainSlack) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_coord();
      int          lat;
      logic [31:0] c;
      c = $urandom();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
         end
         4, 5, 6, 7: begin
            // few cells around zero: negative wrap and the upper corner
            lat = int'($urandom_range(0, 18)) - 9;
            c   = 32'(lat * OneFx) | 32'($urandom_range(0, 4095));
         end
         8: begin
            case ($urandom_range(0, 3))
               0:       c[11:0] = 12'h000;
               1:       c[11:0] = 12'hFFF;
               2:       c[11:0] = 12'h800;
               default: c[11:0] = 12'h001;
            endcase
         end
         default: c[31:12] = $urandom_range(0, 1) ? 20'h80000 : 20'h7FFFF;
      endcase
      return c;
   endfunction

   task automatic configure(input int phase);
      int          g;
      logic [31:0] wdata;
      logic [31:0] rdata;
      if (phase != 0) begin
         for (int i = 0; i < NumGradients; i++) begin
            case (phase)
               1:       g = GradMax;
               2:       g = GradMin;
               3:       g = GradWrapMin;
               5: begin
                  case ($urandom_range(0, 3))
                     0:       g = GradMax;
                     1:       g = GradMin;
                     2:       g = GradWrapMin;
                     default: g = 0;
                  endcase
               end
               default: g = int'($urandom_range(0, 8191)) - 4096;
            endcase
            // upper bits of the bus carry junk that the block must drop
            wdata = (phase == 3 || $urandom_range(0, 1)) ? $urandom() : '0;
            wdata[12:0] = 13'(g);
            csr_write(i, wdata);
         end
      end
      if (phase == 3) begin
         for (int i = NumGradients; i < 2 ** CsrIdxWidth; i++) begin
            csr_write(i, $urandom());
         end
      end
      for (int i = 0; i < NumGradients; i++) begin
         csr_read(i, rdata);
         if (rdata[12:0] !== sb.grad_tab[i][12:0]) begin
            $display("%0t: gradient %0d readback: expected %h, got %h",
                     $time, i, sb.grad_tab[i][12:0], rdata[12:0]);
            csr_errors++;
         end
      end
   endtask

   task automatic run_points(input int count, input int max_gap);
      int burst;
      burst = $urandom_range(1, 24);
      for (int n = 0; n < count; n++) begin
         send_point(pick_coord(), pick_coord());
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(1, 24);
            if (max_gap > 0) begin
               idle_cycles($urandom_range(1, max_gap));
            end
         end
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < NumPhases; phase++) begin
         configure(phase);
         if (phase == 0) begin
            rx_mode = RX_ALWAYS;
            for (int i = 0; i < NumDirected; i++) begin
               send_point(DirX[i], DirY[i]);
            end
            req_tvalid <= 1'b0;
            run_points(PhasePoints - 30, 0);
         end else begin
            rx_mode = rx_mode_type'(phase % 4);
            run_points(PhasePoints, 1 + (phase % 4) * 3);
         end
         wait_drained();
      end
      $display("Sent %0d points over %0d gradient table settings (reset, extremes, random).",
               points_sent, NumPhases);
      $display("Checked %0d noise words; %0d noise and %0d register errors.",
               sb.checked, sb.errors, csr_errors);
      if (sb.errors == 0 && csr_errors == 0 && sb.pending_noise.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
